>>> rtl/tmma_pkg.sv
// ----------------------------------------------------------------------------
// Trend min / max / mean accumulator package
// Shared sizes, register and request codes, beat types and the table entry.
// ----------------------------------------------------------------------------
package tmma_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int MAX_COUNT   = 65535;
    localparam int ENTRY_AW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    localparam int SUM_W     = 34;
    localparam int VAL_W     = 16;
    localparam int COUNT_W   = 16;
    localparam int STATUS_W  = 8;
    localparam int IDX_W     = 6;
    localparam int LATEST_W  = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [VAL_W-1:0] MIN_START = 16'h7fff;

    localparam logic [CFG_IDX_W-1:0] CFG_UNDEF_IN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDEF_OUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LATEST    = 2'd2;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef struct packed {
        logic                       req_type;
        logic [IDX_W-1:0]           param_index;
        logic signed [VAL_W-1:0]    sample_value;
        logic [STATUS_W-1:0]        status_bits;
        logic                       channel_enabled;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]           entry_index;
        logic signed [VAL_W-1:0]    mean_value;
        logic signed [VAL_W-1:0]    min_value;
        logic signed [VAL_W-1:0]    max_value;
        logic [STATUS_W-1:0]        status_out;
        logic                       has_samples;
        logic                       last_result;
    } out_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]    sum;
        logic signed [VAL_W-1:0]    min;
        logic signed [VAL_W-1:0]    max;
        logic [COUNT_W-1:0]         count;
        logic [STATUS_W-1:0]        status;
    } entry_t;

    typedef struct packed {
        logic                       rd_en;
        logic [ENTRY_AW-1:0]        rd_addr;
        logic                       wr_en;
        logic [ENTRY_AW-1:0]        wr_addr;
        entry_t                     wr_entry;
        logic                       clr_all;
    } tbl_req_t;

    function automatic entry_t entry_reset();
        entry_t e;
        e.sum    = '0;
        e.min    = MIN_START;
        e.max    = '0;
        e.count  = '0;
        e.status = '0;
        return e;
    endfunction

endpackage

>>> rtl/tmma_table.sv
// ----------------------------------------------------------------------------
// Statistics table
// One synchronous memory of entries with a registered read port, plus a
// valid bit per entry so that one clear request empties the whole table.
// ----------------------------------------------------------------------------
module tmma_table (
    input  logic             clk,
    input  logic             rst_n,
    input  tmma_pkg::tbl_req_t req,
    output tmma_pkg::entry_t rd_entry
);
    import tmma_pkg::*;

    entry_t                 mem [NUM_ENTRIES];
    entry_t                 rd_data_reg;
    logic                   rd_vld_reg;
    logic [NUM_ENTRIES-1:0] vld_reg;
    logic [NUM_ENTRIES-1:0] vld_next;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_entry;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (req.clr_all)
        begin
            vld_next = '0;
        end
        else if (req.wr_en)
        begin
            vld_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_entry = rd_vld_reg ? rd_data_reg : entry_reset();

`ifndef SYNTHESIS
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        req.clr_all |=> vld_reg == '0)
        else $error("Table still holds valid entries after a clear.");

    a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en && !req.clr_all |=> vld_reg[$past(req.wr_addr)])
        else $error("Written entry is not marked valid.");

    a_no_clear_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.clr_all && req.wr_en))
        else $error("Clear and write requested in the same cycle.");
`endif

endmodule

>>> rtl/tmma_div.sv
// ----------------------------------------------------------------------------
// Mean divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tmma_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tmma_pkg::SUM_W-1:0]    dividend,
    input  logic [tmma_pkg::COUNT_W-1:0]  divisor,
    output logic                          busy,
    output logic                          done,
    output logic [tmma_pkg::SUM_W-1:0]    quotient
);
    import tmma_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]   quo_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] div_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [COUNT_W:0]   rem_sh;
    logic [COUNT_W:0]   diff;
    logic               ge;

    assign rem_sh = {rem_reg, quo_reg[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, div_reg};
    assign diff   = rem_sh - {1'b0, div_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= STEP_W'(SUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/trend_min_max_mean_accumulator.sv
// ----------------------------------------------------------------------------
// Trend min / max / mean accumulator
// Per-parameter statistics table with sample accumulation and flush.
// ----------------------------------------------------------------------------
// The request channel carries add and flush beats; the result channel carries
// one beat per table entry for each flush, in entry order, the final one
// marked by last_result. The configuration channel is always ready; it must be
// written only while the block is idle, which the block itself does not enforce.
// An add beat is a read-modify-write of one table entry: the read is issued
// when the beat is taken and the write in the ADD_WR state, after which the
// next request is taken. A flush walks every entry: FL_DATA takes the memory
// read and starts the bit-serial divider for an entry with samples, FL_DIV
// waits for the quotient, and FL_OUT loads the result register and reads the
// next entry; an empty entry skips FL_DIV. In the same cycle as the final
// result is loaded the table is cleared through its valid bits.
// Reset empties the table and restores the register defaults; no clearing
// pass is needed. When the receiver stalls, the result register holds its
// beat and the walk pauses before loading the next one; add requests are
// still accepted once the walk has finished.
// ----------------------------------------------------------------------------
module trend_min_max_mean_accumulator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  tmma_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output tmma_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tmma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmma_pkg::VAL_W-1:0]      cfg_data
);
    import tmma_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_ADD_WR  = 3'd1;
    localparam logic [2:0] ST_FL_DATA = 3'd2;
    localparam logic [2:0] ST_FL_DIV  = 3'd3;
    localparam logic [2:0] ST_FL_OUT  = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic signed [VAL_W-1:0] undef_in_reg;
    logic signed [VAL_W-1:0] undef_out_reg;
    logic [LATEST_W-1:0]     latest_reg;
    in_item_t                item_reg;
    entry_t                  ent_reg;
    logic [ENTRY_AW-1:0]     cnt_reg;
    logic [ENTRY_AW-1:0]     cnt_next;
    logic                    out_valid_reg;
    out_item_t               out_reg;

    tbl_req_t                tbl_req;
    entry_t                  rd_entry;
    entry_t                  new_entry;

    logic                    div_start;
    logic                    div_busy;
    logic                    div_done;
    logic [SUM_W-1:0]        div_quo;
    logic [SUM_W-1:0]        sum_mag;

    logic signed [VAL_W-1:0] v;
    logic signed [SUM_W-1:0] v_ext;
    logic                    drop_in;
    logic                    is_latest;
    logic                    saturated;
    logic                    add_write;
    logic                    in_fire;
    logic                    out_load;
    logic                    last_entry;
    logic [VAL_W-1:0]        quo_low;
    logic signed [VAL_W-1:0] mean;
    out_item_t               out_next;

    tmma_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (tbl_req),
        .rd_entry (rd_entry)
    );

    tmma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (rd_entry.count),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign v     = item_reg.sample_value;
    assign v_ext = {{(SUM_W - VAL_W){v[VAL_W-1]}}, v};

    always_comb
    begin
        drop_in   = (v == undef_in_reg) || !item_reg.channel_enabled
                    || ({1'b0, item_reg.param_index} >= LATEST_W'(NUM_ENTRIES));
        is_latest = ({1'b0, item_reg.param_index} == latest_reg) && (rd_entry.count != '0);
        saturated = rd_entry.count >= COUNT_W'(MAX_COUNT);
        add_write = !drop_in && (is_latest || !saturated);

        new_entry        = rd_entry;
        new_entry.sum    = is_latest ? v_ext : rd_entry.sum + v_ext;
        new_entry.count  = is_latest ? rd_entry.count : rd_entry.count + 1'b1;
        new_entry.max    = (v > rd_entry.max) ? v : rd_entry.max;
        new_entry.min    = (v < rd_entry.min) ? v : rd_entry.min;
        new_entry.status = rd_entry.status | item_reg.status_bits;
    end

    assign sum_mag    = rd_entry.sum[SUM_W-1] ? SUM_W'(-rd_entry.sum) : SUM_W'(rd_entry.sum);
    assign div_start  = (state_reg == ST_FL_DATA) && (rd_entry.count != '0);
    assign out_load   = (state_reg == ST_FL_OUT) && (!out_valid_reg || out_ready);
    assign last_entry = (cnt_reg == ENTRY_AW'(NUM_ENTRIES - 1));
    assign cnt_next   = cnt_reg + 1'b1;
    assign quo_low    = div_quo[VAL_W-1:0];
    assign mean       = ent_reg.sum[SUM_W-1] ? VAL_W'(-quo_low) : quo_low;

    always_comb
    begin
        out_next.entry_index = IDX_W'(cnt_reg);
        out_next.last_result = last_entry;
        if (ent_reg.count != '0)
        begin
            out_next.mean_value  = mean;
            out_next.min_value   = ent_reg.min;
            out_next.max_value   = ent_reg.max;
            out_next.status_out  = ent_reg.status;
            out_next.has_samples = 1'b1;
        end
        else
        begin
            out_next.mean_value  = undef_out_reg;
            out_next.min_value   = undef_out_reg;
            out_next.max_value   = undef_out_reg;
            out_next.status_out  = '0;
            out_next.has_samples = 1'b0;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        tbl_req.rd_en    = 1'b0;
        tbl_req.rd_addr  = cnt_reg;
        tbl_req.wr_en    = 1'b0;
        tbl_req.wr_addr  = item_reg.param_index[ENTRY_AW-1:0];
        tbl_req.wr_entry = new_entry;
        tbl_req.clr_all  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    tbl_req.rd_en = 1'b1;
                    if (in_data.req_type == REQ_FLUSH)
                    begin
                        tbl_req.rd_addr = '0;
                        state_next      = ST_FL_DATA;
                    end
                    else
                    begin
                        tbl_req.rd_addr = in_data.param_index[ENTRY_AW-1:0];
                        state_next      = ST_ADD_WR;
                    end
                end
            end
            ST_ADD_WR:
            begin
                tbl_req.wr_en = add_write;
                state_next    = ST_IDLE;
            end
            ST_FL_DATA:
            begin
                state_next = div_start ? ST_FL_DIV : ST_FL_OUT;
            end
            ST_FL_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FL_OUT;
                end
            end
            ST_FL_OUT:
            begin
                if (out_load)
                begin
                    if (last_entry)
                    begin
                        tbl_req.clr_all = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        tbl_req.rd_en   = 1'b1;
                        tbl_req.rd_addr = cnt_next;
                        state_next      = ST_FL_DATA;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end
        if (state_reg == ST_FL_DATA)
        begin
            ent_reg <= rd_entry;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            undef_in_reg  <= 16'sh8000;
            undef_out_reg <= 16'sh8000;
            latest_reg    <= LATEST_W'(64);
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                cnt_reg <= '0;
            end
            else if (out_load)
            begin
                cnt_reg <= last_entry ? '0 : cnt_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_UNDEF_IN:  undef_in_reg  <= cfg_data;
                    CFG_UNDEF_OUT: undef_out_reg <= cfg_data;
                    CFG_LATEST:    latest_reg    <= cfg_data[LATEST_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_flush_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.req_type == REQ_FLUSH |=> state_reg == ST_FL_DATA && cnt_reg == '0)
        else $error("Flush beat did not start the walk at the first entry.");

    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && last_entry |=> state_reg == ST_IDLE && out_valid_reg && out_reg.last_result)
        else $error("Final result did not end the flush walk.");

    a_div_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg == ST_FL_DIV)
        else $error("Divider runs outside the divide state.");
`endif

endmodule

>>> tb/trend_stats_checker.sv
// ----------------------------------------------------------------------------
// Trend statistics checker
// Watches the request, result and configuration channels of the trend
// min / max / mean accumulator. It keeps its own copy of the statistics table
// and registers, predicts the result beats of every flush, and compares each
// result beat field by field with the oldest prediction still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module trend_stats_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  tmma_pkg::in_item_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  tmma_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [tmma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmma_pkg::VAL_W-1:0]      cfg_data,
    output int                              mismatch_count,
    output int                              pending_results,
    output int                              results_checked
);
    import tmma_pkg::*;

    logic signed [VAL_W-1:0]    undef_in;
    logic signed [VAL_W-1:0]    undef_out;
    logic [LATEST_W-1:0]        latest_idx;

    longint                     acc_sum    [NUM_ENTRIES];
    int                         acc_min    [NUM_ENTRIES];
    int                         acc_max    [NUM_ENTRIES];
    int                         acc_count  [NUM_ENTRIES];
    logic [STATUS_W-1:0]        acc_status [NUM_ENTRIES];

    out_item_t                  flush_results_due [$];

    function automatic void clear_stats();
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            acc_sum[i]    = 0;
            acc_min[i]    = 32767;
            acc_max[i]    = 0;
            acc_count[i]  = 0;
            acc_status[i] = '0;
        end
    endfunction

    function automatic void accumulate_sample(input in_item_t req);
        int e;
        int v;
        v = $signed(req.sample_value);
        if (req.sample_value == undef_in || !req.channel_enabled
            || req.param_index >= NUM_ENTRIES)
            return;
        e = req.param_index;
        if ({1'b0, req.param_index} == latest_idx && acc_count[e] > 0)
        begin
            acc_count[e] = acc_count[e] - 1;
            acc_sum[e]   = 0;
        end
        else if (acc_count[e] >= MAX_COUNT)
        begin
            return;
        end
        acc_sum[e] = acc_sum[e] + v;
        if (v > acc_max[e])
            acc_max[e] = v;
        if (v < acc_min[e])
            acc_min[e] = v;
        acc_count[e]  = acc_count[e] + 1;
        acc_status[e] = acc_status[e] | req.status_bits;
    endfunction

    function automatic void predict_flush();
        out_item_t r;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            r.entry_index = IDX_W'(i);
            if (acc_count[i] != 0)
            begin
                r.mean_value  = VAL_W'(acc_sum[i] / acc_count[i]);
                r.min_value   = VAL_W'(acc_min[i]);
                r.max_value   = VAL_W'(acc_max[i]);
                r.status_out  = acc_status[i];
                r.has_samples = 1'b1;
            end
            else
            begin
                r.mean_value  = undef_out;
                r.min_value   = undef_out;
                r.max_value   = undef_out;
                r.status_out  = '0;
                r.has_samples = 1'b0;
            end
            r.last_result = (i == NUM_ENTRIES - 1);
            flush_results_due.push_back(r);
        end
        clear_stats();
    endfunction

    task automatic compare_field(input string name, input int entry,
                                 input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: entry %0d %s expected %h actual %h",
                     $time, entry, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        results_checked++;
        if (flush_results_due.size() == 0)
        begin
            $display("%0t: result beat for entry %0d expected none actual %h",
                     $time, got.entry_index, got);
            mismatch_count++;
            return;
        end
        want = flush_results_due.pop_front();
        compare_field("entry_index", want.entry_index, want.entry_index, got.entry_index);
        compare_field("mean_value",  want.entry_index, want.mean_value,  got.mean_value);
        compare_field("min_value",   want.entry_index, want.min_value,   got.min_value);
        compare_field("max_value",   want.entry_index, want.max_value,   got.max_value);
        compare_field("status_out",  want.entry_index, want.status_out,  got.status_out);
        compare_field("has_samples", want.entry_index, want.has_samples, got.has_samples);
        compare_field("last_result", want.entry_index, want.last_result, got.last_result);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            undef_in        = -16'sd32768;
            undef_out       = -16'sd32768;
            latest_idx      = 7'd64;
            mismatch_count  = 0;
            results_checked = 0;
            clear_stats();
            flush_results_due.delete();
            pending_results <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_UNDEF_IN:  undef_in   = cfg_data;
                    CFG_UNDEF_OUT: undef_out  = cfg_data;
                    CFG_LATEST:    latest_idx = cfg_data[LATEST_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (in_data.req_type == REQ_FLUSH)
                    predict_flush();
                else
                    accumulate_sample(in_data);
            end
            pending_results <= flush_results_due.size();
        end
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Trend min / max / mean accumulator testbench
// Drives add and flush beats and register writes into the accumulator, with
// random idle bursts on both channels and a long result stall. A checker
// beside the block predicts and compares every result beat; this module only
// makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    import tmma_pkg::*;

    localparam int CYCLE_LIMIT   = 1500000;
    localparam int LONG_HOLD     = 1500;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 40;
    localparam int PHASE_ITEMS   = 20;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [VAL_W-1:0]       cfg_data;

    int                     mismatch_count;
    int                     pending_results;
    int                     results_checked;

    bit                     idle_on      = 1'b1;
    bit                     hold_results = 1'b0;
    logic [VAL_W-1:0]       cur_undef_in = 16'h8000;
    int                     requests_sent;
    int                     flushes_sent;
    int                     settings_applied;

    trend_min_max_mean_accumulator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    trend_stats_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // The result side stalls in random bursts, and once for a long stretch
    // while the request side keeps offering beats.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_results = 1'b0;
                out_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic in_item_t make_add(input int idx, input int v, input int st,
                                          input bit en = 1'b1);
        in_item_t r;
        r.req_type        = REQ_ADD;
        r.param_index     = IDX_W'(idx);
        r.sample_value    = VAL_W'(v);
        r.status_bits     = STATUS_W'(st);
        r.channel_enabled = en;
        return r;
    endfunction

    function automatic in_item_t make_flush();
        in_item_t r;
        r          = in_item_t'($urandom);
        r.req_type = REQ_FLUSH;
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return cur_undef_in;
            3:       return VAL_W'($urandom_range(0, 40)) - 16'd20;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic in_item_t random_request();
        in_item_t r;
        int       sel;
        r = make_add($urandom_range(0, 1) ? $urandom_range(0, 3)
                                          : $urandom_range(0, NUM_ENTRIES - 1),
                     pick_value(),
                     ($urandom_range(0, 3) == 0) ? $urandom : (1 << $urandom_range(0, 7)));
        sel = $urandom_range(0, 19);
        if (sel < 2)
            r = make_flush();
        else if (sel == 2)
            r.channel_enabled = 1'b0;
        else if (sel == 3)
            r.param_index = IDX_W'($urandom_range(NUM_ENTRIES, 63));
        return r;
    endfunction

    task automatic send_item(input in_item_t item);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
        if (item.req_type == REQ_FLUSH)
            flushes_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [VAL_W-1:0] ui, input logic [VAL_W-1:0] uo,
                                  input int li);
        logic [CFG_IDX_W-1:0] regs [3];
        logic [VAL_W-1:0]     vals [3];
        regs = '{CFG_UNDEF_IN, CFG_UNDEF_OUT, CFG_LATEST};
        vals = '{ui, uo, VAL_W'(li)};
        cfg_valid <= 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_undef_in = ui;
        settings_applied++;
    endtask

    initial
    begin
        in_item_t r;
        int       taken;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_UNDEF_IN;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: empty table, truncation, negative-only entry,
        // ignored samples and the extremes of the value range.
        send_item(make_flush());
        send_item(make_add(0, 32767, 'h80));
        send_item(make_add(0, -32768, 'h01));
        send_item(make_add(0, 1, 'h00));
        send_item(make_add(1, -5, 'h02));
        send_item(make_add(1, -100, 'h04));
        send_item(make_add(2, 50, 'h08, 1'b0));
        send_item(make_add(63, 77, 'h10));
        send_item(make_add(16, 77, 'h10));
        send_item(make_add(15, 7, 'hff));
        send_item(make_add(15, -10, 'h00));
        send_item(make_add(3, -32767, 'h20));
        send_item(make_flush());
        send_item(make_flush());
        wait_idle();

        // The latest-only entry keeps only its newest sample as its sum.
        apply_settings(16'h7fff, 16'h7fff, 0);
        send_item(make_add(0, 32767, 'h01));
        send_item(make_add(0, -32768, 'h10));
        send_item(make_add(0, 100, 'h20));
        send_item(make_add(5, -32768, 'h01));
        send_item(make_add(5, 32766, 'h02));
        send_item(make_add(8, 0, 'h40));
        send_item(make_add(0, -7, 'h00));
        send_item(make_flush());
        wait_idle();

        // Zero marks a missing sample and the last entry is the latest-only one.
        apply_settings(16'h0000, 16'h0000, NUM_ENTRIES - 1);
        idle_on = 1'b0;
        send_item(make_add(4, -32768, 'h80));
        send_item(make_add(4, 32767, 'h40));
        send_item(make_add(15, 5, 'h01));
        send_item(make_add(15, -3, 'h02));
        send_item(make_add(15, 9, 'h04));
        idle_on = 1'b1;
        send_item(make_flush());
        wait_idle();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: apply_settings(16'h8000, 16'h7fff, NUM_ENTRIES);
                1: apply_settings(16'h7fff, 16'h8000, 64);
                2: apply_settings(VAL_W'($urandom), 16'h0000, 0);
                3: apply_settings(VAL_W'($urandom), VAL_W'($urandom), NUM_ENTRIES - 1);
                4: apply_settings(VAL_W'($urandom), VAL_W'($urandom), $urandom_range(0, 64));
                default: apply_settings(16'h8000, 16'h8000, 64);
            endcase
            if (p == 5)
                idle_on = 1'b0;
            if (p == 1)
            begin
                hold_results = 1'b1;
                send_item(make_flush());
                for (int n = 0; n < 6; n++)
                    send_item(make_add($urandom_range(0, 3), pick_value(), $urandom));
                send_item(make_flush());
            end
            taken = 0;
            while (taken < PHASE_ITEMS)
            begin
                r = random_request();
                send_item(r);
                if (r.req_type == REQ_FLUSH || (r.channel_enabled
                    && r.param_index < NUM_ENTRIES && r.sample_value != cur_undef_in))
                    taken++;
            end
            send_item(make_flush());
            wait_idle();
        end

        repeat (END_CYCLES) @(posedge clk);
        $display("tb: %0d request beats, %0d of them flushes, under %0d register settings",
                 requests_sent, flushes_sent, settings_applied + 1);
        $display("tb: %0d result beats checked, including a %0d-cycle result stall",
                 results_checked, LONG_HOLD);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
